FILE: rtl/ucrr_pkg.sv
// Package for the USB control request responder: request, result and command types,
// request and stage codes, and the built-in descriptor tables.
// No dependencies; every other file of the block imports it.
package ucrr_pkg;

    localparam int DESCRIPTOR_BYTES_DEF = 18;
    localparam int QUEUE_DEPTH_DEF      = 2;
    localparam int MAX_DESC_BYTES       = 64;
    localparam int SEND_W               = 7;
    localparam int ROM_BYTES            = 18;
    localparam int ADDR_W               = 7;

    localparam logic [2:0] STAGE_RD_DATA = 3'h1;
    localparam logic [2:0] STAGE_WR_DATA = 3'h3;
    localparam logic [2:0] STAGE_WR_ND   = 3'h5;
    localparam int         STAGE_CHANGE_POS = 11;

    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;

    localparam logic [7:0] DTYPE_DEVICE = 8'h01;
    localparam logic [7:0] DTYPE_CONFIG = 8'h02;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_STALL = 2'd2;
    localparam logic [1:0] ACT_DONE  = 2'd3;

    localparam logic [7:0] DEV_ROM [ROM_BYTES] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h09,
        8'h12, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
    };

    localparam logic [7:0] CFG_ROM [ROM_BYTES] = '{
        8'h09, 8'h02, 8'h12, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00
    };

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_STALL,
        CMD_DONE,
        CMD_STATUS,
        CMD_DESC
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic                  sel_cfg;
        logic [SEND_W-1:0]     send;
        logic [ADDR_W-1:0]     address;
    } t_cmd;

    typedef struct packed {
        logic [15:0] status_word;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] length_requested;
    } t_req;

    typedef struct packed {
        logic [1:0]        action;
        logic [15:0]       data_word;
        logic [1:0]        word_bytes;
        logic              last;
        logic [ADDR_W-1:0] device_address;
    } t_rsp;

    // Bytes past the built-in descriptor read as zero.
    function automatic logic [7:0] desc_byte(input logic sel_cfg,
                                             input logic [SEND_W-2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < (SEND_W-1)'(ROM_BYTES)) begin
            b = sel_cfg ? CFG_ROM[idx[4:0]] : DEV_ROM[idx[4:0]];
        end
        return b;
    endfunction

endpackage

FILE: rtl/ucrr_req_if.sv
// Request channel interface: valid/ready handshake carrying one control-stage event.
// Depends on ucrr_pkg for the payload type.
interface ucrr_req_if import ucrr_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ucrr_rsp_if.sv
// Result channel interface: valid/ready handshake carrying one result item.
// Depends on ucrr_pkg for the payload type.
interface ucrr_rsp_if import ucrr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ucrr_front.sv
// Front end: accepts request items, decodes them into commands and keeps the device address.
// Depends on ucrr_pkg and ucrr_req_if.
module ucrr_front import ucrr_pkg::*; #(
    parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucrr_req_if.sink   i_req,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [ADDR_W-1:0] r_address;
    logic [ADDR_W-1:0] n_address;
    logic [2:0]        w_stage;
    logic              w_active;
    logic [7:0]        w_dtype;
    logic [SEND_W-1:0] w_send;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    assign w_stage  = i_req.payload.status_word[2:0];
    assign w_active = i_req.payload.status_word[STAGE_CHANGE_POS] &&
                      (w_stage == STAGE_RD_DATA || w_stage == STAGE_WR_DATA ||
                       w_stage == STAGE_WR_ND);
    assign w_dtype  = i_req.payload.value_word[15:8];

    // Clamp to the descriptor length; the clamp keeps the count within SEND_W bits.
    assign w_send = (i_req.payload.length_requested < 16'(DESCRIPTOR_BYTES)) ?
                    i_req.payload.length_requested[SEND_W-1:0] : SEND_W'(DESCRIPTOR_BYTES);

    always_comb begin
        n_address     = r_address;
        o_cmd.kind    = CMD_NONE;
        o_cmd.sel_cfg = (w_dtype == DTYPE_CONFIG);
        o_cmd.send    = w_send;
        if (w_active) begin
            unique case (i_req.payload.request_code)
                REQ_GET_DESCRIPTOR: begin
                    if (w_dtype == DTYPE_DEVICE || w_dtype == DTYPE_CONFIG) begin
                        o_cmd.kind = CMD_DESC;
                    end else begin
                        o_cmd.kind = CMD_STALL;
                    end
                end
                REQ_SET_ADDRESS: begin
                    o_cmd.kind = CMD_DONE;
                    n_address  = i_req.payload.value_word[ADDR_W-1:0];
                end
                REQ_SET_CONFIG: o_cmd.kind = CMD_DONE;
                REQ_GET_STATUS: o_cmd.kind = CMD_STATUS;
                default:        o_cmd.kind = CMD_STALL;
            endcase
        end
        // Each command carries the address as it stands after its own request.
        o_cmd.address = n_address;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= '0;
        end else if (o_push) begin
            r_address <= n_address;
        end
    end

endmodule

FILE: rtl/ucrr_queue.sv
// Short command queue between the decoder and the result sequencer.
// Depends on ucrr_pkg for the command type.
module ucrr_queue import ucrr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("command popped from an empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count failed to follow a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count failed to follow a pop");

endmodule

FILE: rtl/ucrr_back.sv
// Result sequencer: expands the head command into result items in an output
// register, one per cycle while it is free. Depends on ucrr_pkg, ucrr_rsp_if.
module ucrr_back import ucrr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    ucrr_rsp_if.source o_rsp
);

    logic              r_out_valid;
    t_rsp              r_rsp;
    logic [SEND_W-1:0] r_pos;
    logic              w_load;
    logic              w_step;
    t_rsp              w_rsp;
    logic [SEND_W:0]   w_pos_hi;
    logic [SEND_W:0]   w_pos_end;
    logic [SEND_W-1:0] w_pos_hi_idx;
    logic              w_hi_ok;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    assign w_load = !r_out_valid || o_rsp.ready;
    assign w_step = i_head_valid && w_load;
    assign o_pop  = w_step && w_rsp.last;

    assign w_pos_hi     = {1'b0, r_pos} + 1'b1;
    assign w_pos_end    = {1'b0, r_pos} + 2'd2;
    assign w_pos_hi_idx = w_pos_hi[SEND_W-1:0];
    assign w_hi_ok      = (w_pos_hi < {1'b0, i_head.send});

    always_comb begin
        w_rsp.action         = ACT_NONE;
        w_rsp.data_word      = '0;
        w_rsp.word_bytes     = 2'd0;
        w_rsp.last           = 1'b1;
        w_rsp.device_address = i_head.address;
        unique case (i_head.kind)
            CMD_NONE:   w_rsp.action = ACT_NONE;
            CMD_STALL:  w_rsp.action = ACT_STALL;
            CMD_DONE:   w_rsp.action = ACT_DONE;
            CMD_STATUS: begin
                w_rsp.action     = ACT_DATA;
                w_rsp.word_bytes = 2'd2;
            end
            CMD_DESC: begin
                w_rsp.action = ACT_DATA;
                // A zero-length request still gets one empty last word.
                if (i_head.send != '0) begin
                    w_rsp.data_word[7:0] = desc_byte(i_head.sel_cfg, r_pos[SEND_W-2:0]);
                    w_rsp.word_bytes     = 2'd1;
                    if (w_hi_ok) begin
                        w_rsp.data_word[15:8] =
                            desc_byte(i_head.sel_cfg, w_pos_hi_idx[SEND_W-2:0]);
                        w_rsp.word_bytes      = 2'd2;
                    end
                    w_rsp.last = (w_pos_end >= {1'b0, i_head.send});
                end
            end
            default:    w_rsp.action = ACT_STALL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_pos       <= w_rsp.last ? '0 : w_pos_end[SEND_W-1:0];
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_rsp <= w_rsp;
        end
    end

    a_pos_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos[0] == 1'b0)
        else $error("descriptor byte position is odd");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_pos == '0))
        else $error("byte position left over without a pending command");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_rsp.valid && o_rsp.payload.last))
        else $error("command retired without a last result");

endmodule

FILE: rtl/usb_control_request_responder.sv
// Top level of the USB control request responder: decoder, command queue, result sequencer.
// Depends on ucrr_pkg, ucrr_req_if, ucrr_rsp_if, ucrr_front, ucrr_queue and ucrr_back.
//
//   Channel  Dir  Payload                                                  Handshake
//   i_req    in   status_word, request_code, value_word, length_requested  valid/ready
//   o_rsp    out  action, data_word, word_bytes, last, device_address      valid/ready
//
// A request item is decoded in the cycle it is accepted and enters a command queue of
// QUEUE_DEPTH entries; its first result passes a queue slot, then the output register.
// The sequencer produces one result per cycle while its output register is free: a
// descriptor of n clamped bytes, ceil(n / 2) but at least one (nine for 18), else one.
// Input ready drops only while the command queue is full; the output register holds a
// result until it is taken. Reset clears the queue, output valid and the device address.
module usb_control_request_responder import ucrr_pkg::*; #(
    parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucrr_req_if.sink   i_req,
    ucrr_rsp_if.source o_rsp
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_head_valid;
    t_cmd w_cmd;
    t_cmd w_head;

    ucrr_front #(
        .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    ucrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    ucrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_rsp        (o_rsp)
    );

endmodule
